/* hdl/tcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int CELLS     = ROWS * COLUMNS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int ROW_W     = $clog2(ROWS);
	localparam int COL_W     = $clog2(COLUMNS + 1);
	localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR = 8'h0a;
	localparam logic [7:0] ATTR_RESET   = 8'h0f;

	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_PUT,
		CMD_NEWLINE,
		CMD_CLEAR,
		CMD_READ,
		CMD_READ_OOR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [7:0]        ch;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ_WAIT,
		ST_SCROLL,
		ST_BLANK
	} back_state_t;

endpackage

`default_nettype wire

/* hdl/tcw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hdl/tcw_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_front import tcw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] op,
	input  wire logic [7:0] character,
	input  wire logic [4:0] read_row,
	input  wire logic [6:0] read_col,
	input  wire logic       init_busy,
	output logic            cmd_valid,
	output cmd_t            cmd,
	input  wire logic       cmd_pop
);

	cmd_t              cmd_in;
	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              read_in_range;

	// Classify the incoming transaction and resolve the read address up front
	always_comb begin
		read_in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLUMNS);
		cmd_in.ch     = character;
		cmd_in.addr   = ADDR_W'(32'(read_row) * COLUMNS + 32'(read_col));
		case (op)
			OP_PUT:   cmd_in.kind = (character == NEWLINE_CHAR) ? CMD_NEWLINE : CMD_PUT;
			OP_CLEAR: cmd_in.kind = CMD_CLEAR;
			OP_READ:  cmd_in.kind = read_in_range ? CMD_READ : CMD_READ_OOR;
			default:  cmd_in.kind = CMD_NOP;
		endcase
	end

	assign in_ready  = (count_q != QCNT_W'(QUEUE_DEPTH)) && !init_busy;
	assign push      = in_valid && in_ready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

endmodule

`default_nettype wire

/* hdl/tcw_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcw_back import tcw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       cmd_valid,
	input  wire cmd_t       cmd,
	output logic            cmd_pop,
	output logic            init_busy,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [4:0]      cursor_row,
	output logic [6:0]      cursor_col,
	output logic [7:0]      cell_char,
	output logic [7:0]      cell_attr,
	output logic            scrolled
);

	back_state_t       state_q;
	back_state_t       state_d;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  row_d;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  col_d;
	logic [7:0]        attr_q;
	logic              out_valid_q;
	logic              init_q;
	logic [ADDR_W-1:0] src_q;
	logic              src_end_q;
	logic              copy_v_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic [ADDR_W-1:0] blank_addr_q;
	logic              scroll_q;
	logic              pend_q;
	logic [7:0]        pend_ch_q;

	logic [ROW_W-1:0]  res_row_q;
	logic [COL_W-1:0]  res_col_q;
	logic [7:0]        res_char_q;
	logic [7:0]        res_attr_q;
	logic              res_scr_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [15:0]       ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	logic [15:0]       ram_rdata;

	logic              res_load;
	logic [7:0]        res_char;
	logic [7:0]        res_attr;
	logic              res_scr;
	logic              scroll_start;
	logic              scroll_char;
	logic              clear_start;
	logic              issue;
	logic              col_full;
	logic              row_last;
	logic              blank_end;
	logic              copy_end;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] next_base;

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid && (!out_valid_q || out_ready);
	assign col_full  = (col_q >= COL_W'(COLUMNS));
	assign row_last  = (row_q == ROW_W'(ROWS - 1));
	assign blank_end = (blank_addr_q == ADDR_W'(CELLS - 1));
	assign copy_end  = copy_v_s1 && (dst_s1 == ADDR_W'(LAST_BASE - 1));
	assign issue     = (state_q == ST_SCROLL) && !src_end_q;
	assign cur_addr  = ADDR_W'(32'(row_q) * COLUMNS + 32'(col_q));
	assign next_base = ADDR_W'((32'(row_q) + 32'd1) * COLUMNS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					case (cmd.kind)
						CMD_PUT:     if (col_full && row_last) state_d = ST_SCROLL;
						CMD_NEWLINE: if (row_last) state_d = ST_SCROLL;
						CMD_CLEAR:   state_d = ST_BLANK;
						CMD_READ:    state_d = ST_READ_WAIT;
						default:     state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ_WAIT: state_d = ST_IDLE;
			ST_SCROLL:    if (copy_end) state_d = ST_BLANK;
			ST_BLANK:     if (blank_end) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we       = 1'b0;
		ram_waddr    = blank_addr_q;
		ram_wdata    = '0;
		ram_raddr    = src_q;
		row_d        = row_q;
		col_d        = col_q;
		res_load     = 1'b0;
		res_char     = '0;
		res_attr     = '0;
		res_scr      = 1'b0;
		scroll_start = 1'b0;
		scroll_char  = 1'b0;
		clear_start  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					case (cmd.kind)
						CMD_PUT: begin
							ram_wdata = {attr_q, cmd.ch};
							if (!col_full) begin
								ram_we    = 1'b1;
								ram_waddr = cur_addr;
								col_d     = col_q + COL_W'(1);
								res_load  = 1'b1;
							end else if (!row_last) begin
								// lazy wrap: land on the next row first
								ram_we    = 1'b1;
								ram_waddr = next_base;
								row_d     = row_q + ROW_W'(1);
								col_d     = COL_W'(1);
								res_load  = 1'b1;
							end else begin
								col_d        = COL_W'(1);
								scroll_start = 1'b1;
								scroll_char  = 1'b1;
							end
						end
						CMD_NEWLINE: begin
							col_d = '0;
							if (!row_last) begin
								row_d    = row_q + ROW_W'(1);
								res_load = 1'b1;
							end else begin
								scroll_start = 1'b1;
							end
						end
						CMD_CLEAR: clear_start = 1'b1;
						CMD_READ:  ram_raddr = cmd.addr;
						default:   res_load = 1'b1;
					endcase
				end
			end
			ST_READ_WAIT: begin
				res_load = 1'b1;
				res_char = ram_rdata[7:0];
				res_attr = ram_rdata[15:8];
			end
			ST_SCROLL: begin
				ram_we    = copy_v_s1;
				ram_waddr = dst_s1;
				ram_wdata = ram_rdata;
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = blank_addr_q;
				// the deferred character lands on the first cell of the new bottom row
				if (pend_q && (blank_addr_q == ADDR_W'(LAST_BASE))) begin
					ram_wdata = {attr_q, pend_ch_q};
				end else begin
					ram_wdata = {(init_q ? ATTR_RESET : attr_q), BLANK_CHAR};
				end
				if (blank_end && !init_q) begin
					res_load = 1'b1;
					res_scr  = scroll_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_BLANK;
			row_q        <= '0;
			col_q        <= '0;
			attr_q       <= ATTR_RESET;
			out_valid_q  <= 1'b0;
			init_q       <= 1'b1;
			src_q        <= '0;
			src_end_q    <= 1'b0;
			copy_v_s1    <= 1'b0;
			blank_addr_q <= '0;
			scroll_q     <= 1'b0;
			pend_q       <= 1'b0;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			copy_v_s1 <= issue;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (scroll_start) begin
				src_q        <= ADDR_W'(COLUMNS);
				src_end_q    <= 1'b0;
				scroll_q     <= 1'b1;
				pend_q       <= scroll_char;
				blank_addr_q <= ADDR_W'(LAST_BASE);
			end
			if (clear_start) begin
				scroll_q     <= 1'b0;
				pend_q       <= 1'b0;
				blank_addr_q <= '0;
			end
			if (issue) begin
				src_q <= src_q + ADDR_W'(1);
				if (src_q == ADDR_W'(CELLS - 1)) begin
					src_end_q <= 1'b1;
				end
			end
			if (state_q == ST_BLANK) begin
				if (blank_end) begin
					init_q <= 1'b0;
				end else begin
					blank_addr_q <= blank_addr_q + ADDR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		dst_s1 <= src_q - ADDR_W'(COLUMNS);
		if (scroll_start) begin
			pend_ch_q <= cmd.ch;
		end
		if (res_load) begin
			res_row_q  <= row_d;
			res_col_q  <= col_d;
			res_char_q <= res_char;
			res_attr_q <= res_attr;
			res_scr_q  <= res_scr;
		end
	end

	assign init_busy  = init_q;
	assign out_valid  = out_valid_q;
	assign cursor_row = 5'(res_row_q);
	assign cursor_col = 7'(res_col_q);
	assign cell_char  = res_char_q;
	assign cell_attr  = res_attr_q;
	assign scrolled   = res_scr_q;

endmodule

`default_nettype wire

/* hdl/text_console_writer.sv */
// Put, newline without scroll, unused op, out-of-range read: registered in the command queue,
// then in the result register; an in-range read adds the screen RAM read between them. One
// of those per cycle while the output is not stalled; a read holds the back end in a wait
// state. A scroll copies rows up through the screen RAM, then blanks the bottom row; a clear
// blanks every cell; both one cell per cycle on the RAM write port. Reset: asynchronous,
// active low; a pass then fills the screen RAM with blanks; no input transaction is accepted until it ends.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] op,
	input  wire logic [7:0] character,
	input  wire logic [4:0] read_row,
	input  wire logic [6:0] read_col,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [4:0]      cursor_row,
	output logic [6:0]      cursor_col,
	output logic [7:0]      cell_char,
	output logic [7:0]      cell_attr,
	output logic            scrolled
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic init_busy;

	tcw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.op       (op),
		.character(character),
		.read_row (read_row),
		.read_col (read_col),
		.init_busy(init_busy),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	tcw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.init_busy (init_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.cell_char (cell_char),
		.cell_attr (cell_attr),
		.scrolled  (scrolled)
	);

endmodule

`default_nettype wire
